@@ hw/rtl/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the button setpoint panel
// Holds the transaction layouts, register indexes, limits and the
// seven-segment decode used by the control and display stages.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int SET_W = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 14;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_MIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTRA_LONG = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SET = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK = 3'd5;

  localparam logic [SET_W-1:0] HOLD_MAX = 14'd16383;
  localparam logic [SET_W-1:0] SET_LIMIT = 14'd9999;
  localparam logic [SET_W-1:0] SET_RESET = 14'd10;
  localparam logic [SET_W-1:0] LOAD_DEFAULT = 14'd10;
  localparam logic [SET_W-1:0] SMALL_STEP = 14'd1;
  localparam logic [SET_W-1:0] BIG_STEP = 14'd10;
  localparam logic [SET_W-1:0] STEP_FLOOR = 14'd11;
  localparam logic [SET_W-1:0] TWO_DIGITS = 14'd100;
  localparam logic [SET_W-1:0] THREE_DIGITS = 14'd1000;

  localparam logic [4:0] LAMP_FIRST = 5'd10;
  localparam logic [4:0] LAMP_LAST = 5'd17;
  localparam logic [2:0] BLINK_TOGGLES = 3'd6;

  localparam logic [2:0] SCAN_THOUSANDS = 3'd1;
  localparam logic [2:0] SCAN_HUNDREDS = 3'd2;
  localparam logic [2:0] SCAN_TENS = 3'd3;
  localparam logic [2:0] SCAN_UNITS = 3'd4;
  localparam logic [2:0] SCAN_LAMP = 3'd5;

  localparam logic [2:0] SEL_THOUSANDS = 3'd0;
  localparam logic [2:0] SEL_HUNDREDS = 3'd1;
  localparam logic [2:0] SEL_TENS = 3'd2;
  localparam logic [2:0] SEL_UNITS = 3'd3;
  localparam logic [2:0] SEL_LAMP = 3'd4;

  localparam int RECIP_SHIFT = 23;
  localparam int TENTH_SHIFT = 19;
  localparam logic [15:0] TENTH_RECIP = 16'd52429;

  typedef struct packed {
    logic [15:0] nv_value;
    logic        anim_tick;
    logic        load_n;
    logic        save_n;
    logic        down_n;
    logic        up_n;
  } item_t;

  typedef struct packed {
    logic [SET_W-1:0] shown;
    logic [2:0]       digit_select;
    logic [4:0]       lamp_code;
    logic [SET_W-1:0] setpoint;
    logic             setpoint_written;
    logic             save_strobe;
    logic             status_led;
  } tick_t;

  typedef struct packed {
    logic             status_led;
    logic             save_strobe;
    logic             setpoint_written;
    logic [SET_W-1:0] setpoint;
    logic [2:0]       digit_select;
    logic [7:0]       segments;
  } result_t;

  function automatic logic [7:0] seg_code(input logic [4:0] code);
    logic [7:0] seg;
    unique case (code)
      5'd0:    seg = 8'h03;
      5'd1:    seg = 8'h9F;
      5'd2:    seg = 8'h25;
      5'd3:    seg = 8'h0D;
      5'd4:    seg = 8'h99;
      5'd5:    seg = 8'h49;
      5'd6:    seg = 8'h41;
      5'd7:    seg = 8'h1F;
      5'd8:    seg = 8'h01;
      5'd9:    seg = 8'h09;
      5'd10:   seg = 8'hFE;
      5'd11:   seg = 8'hFD;
      5'd12:   seg = 8'hFB;
      5'd13:   seg = 8'hF7;
      5'd14:   seg = 8'hEF;
      5'd15:   seg = 8'hDF;
      5'd16:   seg = 8'hBF;
      5'd17:   seg = 8'h7F;
      default: seg = 8'hFF;
    endcase
    return seg;
  endfunction

  // Scaled reciprocal of the place value, used as (value * recip) >> RECIP_SHIFT.
  function automatic logic [23:0] place_recip(input logic [2:0] sel);
    logic [23:0] r;
    unique case (sel)
      SEL_THOUSANDS: r = 24'd8389;
      SEL_HUNDREDS:  r = 24'd83888;
      SEL_TENS:      r = 24'd838864;
      default:       r = 24'd8388608;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/bsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsp_ctrl: button handling, setpoint and scan state
// Holds the configuration registers and the panel state, updates them for
// one transaction and registers the per-tick fields for the display stages.
// ----------------------------------------------------------------------------
module bsp_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               step,
  input  bsp_pkg::item_t                     item,
  output bsp_pkg::tick_t                     tick
);

  logic [9:0]  press_min;
  logic [13:0] long_press;
  logic [13:0] extra_long;
  logic [6:0]  repeat_len;
  logic [13:0] max_set;
  logic [9:0]  blink_len;

  logic [13:0] set_value;
  logic [2:0]  scan_pos;
  logic [4:0]  lamp_code;
  logic        anim_half;
  logic [13:0] hold_count [4];
  logic [6:0]  repeat_phase;
  logic        blinking;
  logic [9:0]  blink_timer;
  logic [2:0]  blink_count;
  logic        led_level;

  logic [13:0] set_value_next;
  logic [2:0]  scan_pos_next;
  logic [4:0]  lamp_code_next;
  logic        anim_half_next;
  logic [13:0] hold_count_next [4];
  logic [6:0]  repeat_phase_next;
  logic        blinking_next;
  logic [9:0]  blink_timer_next;
  logic [2:0]  blink_count_next;
  logic        led_level_next;
  logic [2:0]  sel;
  logic        written;

  logic [3:0]  pressed;
  logic [3:0]  big_hit;
  logic [3:0]  held_hit;
  logic [3:0]  short_hit;
  logic [13:0] hold_inc [4];
  logic [13:0] eff_max;
  logic [6:0]  period;
  logic [7:0]  phase_sum;
  logic        fire;

  always_comb begin
    eff_max = (max_set == '0) ? 14'd1 : ((max_set > bsp_pkg::SET_LIMIT) ?
              bsp_pkg::SET_LIMIT : max_set);
    period = (repeat_len == '0) ? 7'd1 : repeat_len;
    phase_sum = {1'b0, repeat_phase} + 8'd1;
    fire = phase_sum >= {1'b0, period};
    repeat_phase_next = fire ? '0 : phase_sum[6:0];

    pressed = {~item.load_n, ~item.save_n, ~item.down_n, ~item.up_n};
    for (int i = 0; i < 4; i++) begin
      hold_inc[i] = (hold_count[i] < bsp_pkg::HOLD_MAX) ? hold_count[i] + 14'd1 :
                    hold_count[i];
      big_hit[i] = pressed[i] && fire && (hold_inc[i] >= extra_long);
      held_hit[i] = pressed[i] && fire && (hold_inc[i] < extra_long) &&
                    (hold_inc[i] >= long_press);
      short_hit[i] = !pressed[i] && (hold_count[i] >= {4'd0, press_min}) &&
                     (hold_count[i] < long_press);
      hold_count_next[i] = pressed[i] ? hold_inc[i] : '0;
    end
  end

  logic [13:0] up_sum;
  logic [13:0] up_value;
  logic [13:0] down_size;
  logic [13:0] down_diff;
  logic [13:0] down_value;
  logic        up_step;
  logic        down_step;

  always_comb begin
    up_step = big_hit[0] || held_hit[0] || short_hit[0];
    down_step = big_hit[1] || held_hit[1] || short_hit[1];

    up_sum = set_value + (big_hit[0] ? bsp_pkg::BIG_STEP : bsp_pkg::SMALL_STEP);
    up_value = up_step ? ((up_sum > eff_max) ? eff_max : up_sum) : set_value;

    down_size = (big_hit[1] && up_value >= bsp_pkg::STEP_FLOOR) ? bsp_pkg::BIG_STEP :
                bsp_pkg::SMALL_STEP;
    down_diff = up_value - down_size;
    if (!down_step) begin
      down_value = up_value;
    end else if (down_diff < 14'd1) begin
      down_value = 14'd1;
    end else if (down_diff > eff_max) begin
      down_value = eff_max;
    end else begin
      down_value = down_diff;
    end

    if (!short_hit[3]) begin
      set_value_next = down_value;
    end else if (item.nv_value != '0 && item.nv_value <= {2'd0, eff_max}) begin
      set_value_next = item.nv_value[13:0];
    end else begin
      set_value_next = (eff_max < bsp_pkg::LOAD_DEFAULT) ? eff_max : bsp_pkg::LOAD_DEFAULT;
    end
    written = up_step || down_step || short_hit[3];
  end

  logic [4:0]  lamp_step;
  logic [10:0] timer_sum;

  always_comb begin
    lamp_step = (lamp_code >= bsp_pkg::LAMP_LAST) ? bsp_pkg::LAMP_FIRST : lamp_code + 5'd1;
    lamp_code_next = lamp_code;
    anim_half_next = anim_half;
    if (item.anim_tick) begin
      if (set_value == 14'd1) begin
        anim_half_next = !anim_half;
        if (anim_half) begin
          lamp_code_next = lamp_step;
        end
      end else begin
        lamp_code_next = lamp_step;
      end
    end

    if (scan_pos >= bsp_pkg::SCAN_THOUSANDS && scan_pos <= bsp_pkg::SCAN_UNITS) begin
      sel = scan_pos - 3'd1;
      scan_pos_next = scan_pos + 3'd1;
    end else begin
      sel = bsp_pkg::SEL_LAMP;
      if (set_value < bsp_pkg::TWO_DIGITS) begin
        scan_pos_next = bsp_pkg::SCAN_TENS;
      end else if (set_value < bsp_pkg::THREE_DIGITS) begin
        scan_pos_next = bsp_pkg::SCAN_HUNDREDS;
      end else begin
        scan_pos_next = bsp_pkg::SCAN_THOUSANDS;
      end
    end

    blinking_next = blinking || short_hit[2];
    blink_timer_next = blink_timer;
    blink_count_next = blink_count;
    led_level_next = led_level;
    timer_sum = {1'b0, blink_timer} + 11'd1;
    if (blinking_next) begin
      blink_timer_next = timer_sum[9:0];
      if (timer_sum >= {1'b0, blink_len}) begin
        blink_timer_next = '0;
        blink_count_next = blink_count + 3'd1;
        led_level_next = !led_level;
        if (blink_count_next >= bsp_pkg::BLINK_TOGGLES) begin
          blink_count_next = '0;
          blinking_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_min <= 10'd30;
      long_press <= 14'd1000;
      extra_long <= 14'd10000;
      repeat_len <= 7'd100;
      max_set <= 14'd2000;
      blink_len <= 10'd500;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bsp_pkg::CFG_PRESS_MIN:  press_min <= cfg_data[9:0];
        bsp_pkg::CFG_LONG_PRESS: long_press <= cfg_data;
        bsp_pkg::CFG_EXTRA_LONG: extra_long <= cfg_data;
        bsp_pkg::CFG_REPEAT:     repeat_len <= cfg_data[6:0];
        bsp_pkg::CFG_MAX_SET:    max_set <= cfg_data;
        bsp_pkg::CFG_BLINK:      blink_len <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_value <= bsp_pkg::SET_RESET;
      scan_pos <= bsp_pkg::SCAN_THOUSANDS;
      lamp_code <= bsp_pkg::LAMP_FIRST;
      anim_half <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        hold_count[i] <= '0;
      end
      repeat_phase <= '0;
      blinking <= 1'b0;
      blink_timer <= '0;
      blink_count <= '0;
      led_level <= 1'b0;
    end else if (step) begin
      set_value <= set_value_next;
      scan_pos <= scan_pos_next;
      lamp_code <= lamp_code_next;
      anim_half <= anim_half_next;
      for (int i = 0; i < 4; i++) begin
        hold_count[i] <= hold_count_next[i];
      end
      repeat_phase <= repeat_phase_next;
      blinking <= blinking_next;
      blink_timer <= blink_timer_next;
      blink_count <= blink_count_next;
      led_level <= led_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tick.shown <= set_value;
      tick.digit_select <= sel;
      tick.lamp_code <= lamp_code_next;
      tick.setpoint <= set_value_next;
      tick.setpoint_written <= written;
      tick.save_strobe <= short_hit[2];
      tick.status_led <= led_level_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (set_value >= 14'd1) && (set_value <= bsp_pkg::SET_LIMIT))
    else $error("Setpoint left its legal range.");

  assert property (@(posedge clk) disable iff (rst)
    (scan_pos >= bsp_pkg::SCAN_THOUSANDS) && (scan_pos <= bsp_pkg::SCAN_LAMP))
    else $error("Scan position left the display range.");

  assert property (@(posedge clk) disable iff (rst)
    (lamp_code >= bsp_pkg::LAMP_FIRST) && (lamp_code <= bsp_pkg::LAMP_LAST))
    else $error("Lamp code left the animation range.");

  assert property (@(posedge clk) disable iff (rst)
    (blink_count != '0) |-> blinking)
    else $error("Blink count is running while the lamp is not blinking.");

  assert property (@(posedge clk) disable iff (rst)
    step && short_hit[3] |=> (set_value <= bsp_pkg::SET_LIMIT) && tick.setpoint_written)
    else $error("Load did not apply the setpoint.");

endmodule

@@ hw/rtl/bsp_digit.sv @@
// ----------------------------------------------------------------------------
// bsp_digit: digit extraction and segment decode
// Splits the shown setpoint into the scanned decimal digit over two
// registered multiply stages and builds the result transaction.
// ----------------------------------------------------------------------------
module bsp_digit (
  input  logic             clk,
  input  logic             en_div,
  input  logic             en_seg,
  input  bsp_pkg::tick_t   tick,
  output bsp_pkg::result_t result
);

  bsp_pkg::tick_t tick_q;
  logic [13:0]    quot;
  logic [37:0]    place_prod;
  logic [29:0]    tenth_prod;
  logic [10:0]    tenth;
  logic [13:0]    rem_wide;
  logic [4:0]     code;
  logic [7:0]     seg;

  assign place_prod = {24'd0, tick.shown} * {14'd0, bsp_pkg::place_recip(tick.digit_select)};

  always_ff @(posedge clk) begin
    if (en_div) begin
      tick_q <= tick;
      quot <= place_prod[bsp_pkg::RECIP_SHIFT +: 14];
    end
  end

  always_comb begin
    tenth_prod = {16'd0, quot} * {14'd0, bsp_pkg::TENTH_RECIP};
    tenth = tenth_prod[bsp_pkg::TENTH_SHIFT +: 11];
    rem_wide = quot - ({3'd0, tenth} * 14'd10);
    code = (tick_q.digit_select == bsp_pkg::SEL_LAMP) ? tick_q.lamp_code :
           {1'b0, rem_wide[3:0]};
    seg = bsp_pkg::seg_code(code);
    if (tick_q.digit_select == bsp_pkg::SEL_TENS) begin
      seg = seg - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_seg) begin
      result.segments <= seg;
      result.digit_select <= tick_q.digit_select;
      result.setpoint <= tick_q.setpoint;
      result.setpoint_written <= tick_q.setpoint_written;
      result.save_strobe <= tick_q.save_strobe;
      result.status_led <= tick_q.status_led;
    end
  end

endmodule

@@ hw/rtl/button_setpoint_panel_top.sv @@
// ----------------------------------------------------------------------------
// button_setpoint_panel_top: front panel with buttons and scanned display
// Throughput: one transaction per cycle while m_tready does not stall the output.
// Four elastic stages (input, update, place multiply, segment decode) each
// advance when the stage after them is empty or moving.
// Reset: synchronous; empties the pipeline and restores registers and state.
// ----------------------------------------------------------------------------
module button_setpoint_panel_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // up_n, down_n, save_n, load_n, anim_tick, nv_value[15:0], zero pad
  input  logic [bsp_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // segments[7:0], digit_select[2:0], setpoint[13:0], setpoint_written,
  // save_strobe, status_led, zero pad
  output logic [bsp_pkg::OUT_DATA_W-1:0]      m_tdata
);

  logic             in_valid;
  logic             upd_valid;
  logic             div_valid;
  logic             out_valid;
  logic             in_ready;
  logic             upd_ready;
  logic             div_ready;
  logic             out_ready;
  bsp_pkg::item_t   item;
  bsp_pkg::tick_t   tick;
  bsp_pkg::result_t result;

  assign out_ready = !out_valid || m_tready;
  assign div_ready = !div_valid || out_ready;
  assign upd_ready = !upd_valid || div_ready;
  assign in_ready = !in_valid || upd_ready;
  assign s_tready = in_ready;
  assign m_tvalid = out_valid;
  assign m_tdata = {{(bsp_pkg::OUT_DATA_W - $bits(bsp_pkg::result_t)){1'b0}}, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      upd_valid <= 1'b0;
      div_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid <= s_tvalid;
      end
      if (upd_ready) begin
        upd_valid <= in_valid;
      end
      if (div_ready) begin
        div_valid <= upd_valid;
      end
      if (out_ready) begin
        out_valid <= div_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && in_ready) begin
      item <= s_tdata[$bits(bsp_pkg::item_t)-1:0];
    end
  end

  bsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (in_valid && upd_ready),
    .item      (item),
    .tick      (tick)
  );

  bsp_digit u_digit (
    .clk    (clk),
    .en_div (upd_valid && div_ready),
    .en_seg (div_valid && out_ready),
    .tick   (tick),
    .result (result)
  );

endmodule
